/* sv/rcfe_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the random colour fade engine
// no dependencies; compiled before the interfaces and modules

package rcfe_pkg;

	localparam int ACC_W   = 32;
	localparam int CYCLE_W = 16;
	localparam int DATA_W  = 16;

	localparam logic [7:0]  MIN_PERIOD  = 8'd11;
	localparam logic [15:0] CYCLE_RESET = 16'd100;

	// mode register codes, mode 3 behaves as direct
	localparam logic [1:0] MODE_SHARED  = 2'd0;
	localparam logic [1:0] MODE_PER_LED = 2'd1;
	localparam logic [1:0] MODE_DIRECT  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE = 1'b1;

	typedef struct packed {
		logic [7:0]  led_index;
		logic        first_of_frame;
		logic [31:0] random_word;
		logic [7:0]  cur_red;
		logic [7:0]  cur_green;
		logic [7:0]  cur_blue;
	} item_t;

	typedef struct packed {
		logic [7:0] out_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       retargeted;
	} result_t;

	// one memory row per led, channel 0 red, 1 green, 2 blue
	typedef struct packed {
		logic [2:0][ACC_W-1:0] acc;
		logic [2:0][ACC_W-1:0] step;
		logic [7:0]            count;
		logic [7:0]            period;
	} led_row_t;

	typedef struct packed {
		logic               start;
		logic [7:0]         diff;
		logic               neg;
		logic [CYCLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] step;
	} div_rsp_t;

endpackage

/* sv/rcfe_item_if.sv */
`timescale 1ns / 1ps
// input item channel: valid, ready and one item
// depends on rcfe_pkg

interface rcfe_item_if;
	import rcfe_pkg::*;

	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/rcfe_result_if.sv */
`timescale 1ns / 1ps
// result channel: valid, ready and one result item
// depends on rcfe_pkg

interface rcfe_result_if;
	import rcfe_pkg::*;

	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/rcfe_cfg_if.sv */
`timescale 1ns / 1ps
// configuration write channel: valid, ready, register index and data
// depends on rcfe_pkg

interface rcfe_cfg_if;
	import rcfe_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/rcfe_serial_div.sv */
`timescale 1ns / 1ps
// bit-serial restoring divider for the fade step, one quotient bit per cycle
// depends on rcfe_pkg

module rcfe_serial_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rcfe_pkg::div_req_t req,
	output rcfe_pkg::div_rsp_t rsp
);
	import rcfe_pkg::*;

	localparam int QW = 8 + FRAC_BITS;
	localparam int CW = $clog2(QW);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [QW-1:0]      dvd_q;
	logic [QW-1:0]      quo_q;
	logic [CYCLE_W-1:0] rem_q;
	logic [CYCLE_W-1:0] divisor_q;
	logic               neg_q;
	logic [ACC_W-1:0]   step_q;

	logic [CYCLE_W:0]   trial;
	logic               qbit;
	logic [CYCLE_W:0]   rem_next;
	logic [QW-1:0]      quo_final;
	logic [ACC_W-1:0]   mag;

	// one restoring step: bring down the next dividend bit and try the divisor
	always_comb begin
		trial     = {rem_q, dvd_q[QW-1]};
		qbit      = (trial >= {1'b0, divisor_q});
		rem_next  = qbit ? (trial - {1'b0, divisor_q}) : trial;
		quo_final = {quo_q[QW-2:0], qbit};
		mag       = ACC_W'(quo_final);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			dvd_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
			neg_q     <= 1'b0;
			step_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				dvd_q     <= {req.diff, {FRAC_BITS{1'b0}}};
				quo_q     <= '0;
				rem_q     <= '0;
				divisor_q <= req.divisor;
				neg_q     <= req.neg;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[QW-2:0], 1'b0};
				quo_q <= quo_final;
				rem_q <= rem_next[CYCLE_W-1:0];
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					// zero divisor holds the colour
					if (divisor_q == '0) begin
						step_q <= '0;
					end else if (neg_q) begin
						step_q <= '0 - mag;
					end else begin
						step_q <= mag;
					end
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.step = step_q;

endmodule

/* sv/random_color_fade_engine.sv */
`timescale 1ns / 1ps
// top level of the random colour fade engine: sequencer, led state memory,
// configuration registers; depends on rcfe_pkg, the channel interfaces and rcfe_serial_div
//
// channel   | direction | payload                                        | transfer when
// ----------+-----------+------------------------------------------------+--------------------
// items     | in        | led_index, first_of_frame, random_word, colour | items.valid & ready
// results   | out       | out_index, red, green, blue, retargeted        | results.valid & ready
// cfg       | in        | index (0 mode, 1 cycle_count), data            | cfg.valid & ready
//
// sequence: direct mode or an led beyond the table goes from idle straight to finish;
//   a fade visit passes decide, add once per channel, write and finish; a retarget
//   also runs the bit-serial divider, one quotient bit a cycle, once per channel
// reset: after arst_n the led memory is cleared one row a cycle, through every row,
//   with items.ready low; configuration writes are taken throughout
// stalls: a finished result waits in the output register while the next item
//   is taken; the sequencer only waits once it has a second result to hand over

module random_color_fade_engine #(
	parameter int NUM_LEDS  = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rcfe_item_if.sink            items,
	rcfe_result_if.source        results,
	rcfe_cfg_if.sink             cfg
);
	import rcfe_pkg::*;

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_ADD,
		S_WRITE,
		S_FINISH
	} state_t;

	// sequencer and item state
	state_t             state_q;
	logic [AW-1:0]      clr_q;
	item_t              item_q;
	logic [AW-1:0]      addr_q;
	led_row_t           row_q;
	led_row_t           rd_row_q;
	logic               retarget_q;
	logic [CYCLE_W-1:0] div_q;
	logic [1:0]         ch_q;
	logic [2:0][7:0]    res_q;

	// configuration and frame state
	logic [1:0]         mode_q;
	logic [CYCLE_W-1:0] cycle_q;
	logic [CYCLE_W-1:0] frame_cnt_q;
	logic               frame_rt_q;

	// output register
	logic               out_valid_q;
	result_t            out_q;
	logic               out_load;

	// led state memory, one row per led
	led_row_t           led_mem [NUM_LEDS];
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	led_row_t           mem_wdata;

	logic               in_fire;
	logic               led_ok;
	logic [2:0][7:0]    in_cur;
	logic [2:0][7:0]    in_tgt;
	logic [2:0][7:0]    cur_v;
	logic [2:0][7:0]    tgt_v;

	logic               nxt_retarget;
	logic               nxt_frame_rt;
	logic [CYCLE_W-1:0] nxt_frame_cnt;
	logic [7:0]         nxt_count;
	logic [7:0]         nxt_period;
	logic [7:0]         period_byte;

	logic [ACC_W-1:0]   acc_base;
	logic [ACC_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   acc_hi;
	logic [7:0]         acc_byte;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign in_fire = items.valid && items.ready;
	assign led_ok  = (32'(items.payload.led_index) < NUM_LEDS);
	assign in_cur  = {items.payload.cur_blue, items.payload.cur_green, items.payload.cur_red};
	assign in_tgt  = items.payload.random_word[23:0];
	assign cur_v   = {item_q.cur_blue, item_q.cur_green, item_q.cur_red};
	assign tgt_v   = item_q.random_word[23:0];

	assign items.ready   = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign results.valid = out_valid_q;
	assign results.payload = out_q;

	// a finished result moves into the output register once it is free or being emptied
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || results.ready);

	// retarget decision on the row just read
	always_comb begin
		nxt_frame_rt  = frame_rt_q;
		nxt_frame_cnt = frame_cnt_q;
		nxt_retarget  = 1'b0;
		nxt_count     = rd_row_q.count;
		nxt_period    = rd_row_q.period;
		period_byte   = item_q.random_word[31:24];
		if (mode_q == MODE_SHARED) begin
			if (item_q.first_of_frame) begin
				if (frame_cnt_q == cycle_q) begin
					// counter restarts at one and then counts this frame
					nxt_frame_rt  = 1'b1;
					nxt_frame_cnt = CYCLE_W'(2);
				end else begin
					nxt_frame_rt  = 1'b0;
					nxt_frame_cnt = frame_cnt_q + CYCLE_W'(1);
				end
			end
			nxt_retarget = nxt_frame_rt;
		end else begin
			if (rd_row_q.count == rd_row_q.period) begin
				nxt_retarget = 1'b1;
				nxt_period   = (period_byte < MIN_PERIOD) ? MIN_PERIOD : period_byte;
				nxt_count    = 8'd2;
			end else begin
				nxt_count = rd_row_q.count + 8'd1;
			end
		end
	end

	// one channel of accumulate and saturate a cycle
	always_comb begin
		acc_base = retarget_q ? (ACC_W'(cur_v[ch_q]) << FRAC_BITS) : row_q.acc[ch_q];
		acc_sum  = acc_base + row_q.step[ch_q];
		acc_hi   = acc_sum >> (FRAC_BITS + 8);
		if (acc_sum[ACC_W-1]) begin
			acc_byte = 8'd0;
		end else if (acc_hi != '0) begin
			acc_byte = 8'hFF;
		end else begin
			acc_byte = acc_sum[FRAC_BITS +: 8];
		end
	end

	// divider request for the current channel
	always_comb begin
		div_req.start   = (state_q == S_DIV_GO);
		div_req.neg     = (tgt_v[ch_q] < cur_v[ch_q]);
		div_req.diff    = div_req.neg ? (cur_v[ch_q] - tgt_v[ch_q])
		                              : (tgt_v[ch_q] - cur_v[ch_q]);
		div_req.divisor = div_q;
	end

	rcfe_serial_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// memory write port: clearing sweep after reset, else the row write-back
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
		mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
		mem_wdata = (state_q == S_CLEAR) ? led_row_t'('0) : row_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			led_mem[mem_waddr] <= mem_wdata;
		end
		if (in_fire) begin
			rd_row_q <= led_mem[AW'(items.payload.led_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			item_q      <= '0;
			addr_q      <= '0;
			row_q       <= '0;
			retarget_q  <= 1'b0;
			div_q       <= '0;
			ch_q        <= '0;
			res_q       <= '0;
			mode_q      <= MODE_SHARED;
			cycle_q     <= CYCLE_RESET;
			frame_cnt_q <= CYCLE_RESET;
			frame_rt_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// configuration writes
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_MODE:  mode_q  <= cfg.data[1:0];
					REG_CYCLE: cycle_q <= cfg.data[CYCLE_W-1:0];
					default:   ;
				endcase
			end

			// output register: load a finished result, else drop one taken downstream
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= '{out_index: item_q.led_index, red: res_q[0],
				                 green: res_q[1], blue: res_q[2], retargeted: retarget_q};
			end else if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_LEDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						item_q     <= items.payload;
						addr_q     <= AW'(items.payload.led_index);
						retarget_q <= 1'b0;
						ch_q       <= '0;
						if (mode_q != MODE_SHARED && mode_q != MODE_PER_LED) begin
							// direct colour, no state touched
							res_q   <= in_tgt;
							state_q <= S_FINISH;
						end else if (!led_ok) begin
							res_q   <= in_cur;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					// count and period only move in per-led mode
					row_q <= '{acc: rd_row_q.acc, step: rd_row_q.step,
					           count: nxt_count, period: nxt_period};
					if (mode_q == MODE_SHARED) begin
						frame_rt_q  <= nxt_frame_rt;
						frame_cnt_q <= nxt_frame_cnt;
						div_q       <= cycle_q;
					end else begin
						div_q <= CYCLE_W'(nxt_period);
					end
					retarget_q <= nxt_retarget;
					state_q    <= nxt_retarget ? S_DIV_GO : S_ADD;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						row_q.step[ch_q] <= div_rsp.step;
						if (ch_q == 2'd2) begin
							ch_q    <= '0;
							state_q <= S_ADD;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_ADD: begin
					row_q.acc[ch_q] <= acc_sum;
					res_q[ch_q]     <= acc_byte;
					if (ch_q == 2'd2) begin
						ch_q    <= '0;
						state_q <= S_WRITE;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				S_WRITE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hand over once the output register is free or being emptied
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for random_color_fade_engine: directed and random items, an in-bench
// colour predictor and a scoreboard; depends on it, rcfe_pkg and the channel interfaces

module testbench;
	import rcfe_pkg::*;

	localparam int LEDS        = 256;
	localparam int FRAC        = 16;
	localparam int ITEMS       = 1900;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 16;
	localparam int LIMIT       = 3_000_000;

	// mode 3 has no package name, the engine treats it as direct
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	rcfe_item_if   item_ch ();
	rcfe_result_if result_ch ();
	rcfe_cfg_if    cfg_ch ();

	random_color_fade_engine #(
		.NUM_LEDS(LEDS),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.results(result_ch),
		.cfg(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// items waiting for the driver, and colours predicted for accepted items
	item_t   item_backlog[$];
	result_t colour_expect[$];

	// predictor copy of the engine state, per channel rows are 3*led + channel
	logic [ACC_W-1:0]   fade_acc [3*LEDS];
	logic [ACC_W-1:0]   fade_inc [3*LEDS];
	logic [7:0]         visit_count [LEDS];
	logic [7:0]         visit_period [LEDS];
	logic [CYCLE_W-1:0] frame_cnt;
	logic               frame_hit;
	logic [1:0]         mode_q;
	logic [CYCLE_W-1:0] cycle_q;

	int mismatches   = 0;
	int items_queued = 0;
	int send_gap     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	bit no_idle      = 1'b0;
	bit hold_go      = 1'b0;
	bit hold_used    = 1'b0;

	// next colour of one led, advancing the predictor state as the engine would
	function automatic result_t predict_colour(item_t it);
		result_t            r;
		logic [7:0]         cur [3];
		logic [7:0]         tgt [3];
		logic [7:0]         shade [3];
		logic [7:0]         per;
		logic [7:0]         diff;
		logic [CYCLE_W-1:0] divisor;
		logic [63:0]        quot;
		logic               take;
		int                 c;
		int                 k;
		cur[0] = it.cur_red;
		cur[1] = it.cur_green;
		cur[2] = it.cur_blue;
		take = 1'b0;
		divisor = '0;
		for (c = 0; c < 3; c++) begin
			tgt[c] = it.random_word[8*c +: 8];
			shade[c] = cur[c];
		end
		if (mode_q >= MODE_DIRECT) begin
			// direct colour, no state touched
			for (c = 0; c < 3; c++) begin
				shade[c] = tgt[c];
			end
		end else if (int'(it.led_index) < LEDS) begin
			if (mode_q == MODE_SHARED) begin
				// frame counter only moves on the first led of a frame
				if (it.first_of_frame) begin
					if (frame_cnt == cycle_q) begin
						frame_hit = 1'b1;
						frame_cnt = CYCLE_W'(1);
					end else begin
						frame_hit = 1'b0;
					end
					frame_cnt = frame_cnt + 1'b1;
				end
				if (frame_hit) begin
					take = 1'b1;
					divisor = cycle_q;
				end
			end else if (visit_count[it.led_index] == visit_period[it.led_index]) begin
				// own period, never shorter than the minimum
				per = (it.random_word[31:24] < MIN_PERIOD) ? MIN_PERIOD : it.random_word[31:24];
				visit_period[it.led_index] = per;
				visit_count[it.led_index] = 8'd1;
				take = 1'b1;
				divisor = CYCLE_W'(per);
			end
			for (c = 0; c < 3; c++) begin
				k = 3 * int'(it.led_index) + c;
				if (take) begin
					fade_acc[k] = ACC_W'(cur[c]) << FRAC;
					diff = (tgt[c] < cur[c]) ? cur[c] - tgt[c] : tgt[c] - cur[c];
					// zero divisor holds the colour
					if (divisor == 0) begin
						quot = 64'd0;
					end else begin
						quot = (64'(diff) << FRAC) / 64'(divisor);
					end
					fade_inc[k] = (tgt[c] < cur[c]) ? -quot[ACC_W-1:0] : quot[ACC_W-1:0];
				end
				fade_acc[k] = fade_acc[k] + fade_inc[k];
				// negative clamps to black, anything past the byte to full
				if (fade_acc[k][ACC_W-1]) begin
					shade[c] = 8'h00;
				end else if ((fade_acc[k] >> FRAC) > 255) begin
					shade[c] = 8'hFF;
				end else begin
					shade[c] = fade_acc[k][FRAC +: 8];
				end
			end
			if (mode_q == MODE_PER_LED) begin
				visit_count[it.led_index] = visit_count[it.led_index] + 1'b1;
			end
		end
		r.out_index = it.led_index;
		r.red = shade[0];
		r.green = shade[1];
		r.blue = shade[2];
		r.retargeted = take;
		return r;
	endfunction

	// idle length for either side: mostly none, some short, a few long
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// colour byte with the rails favoured
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// mostly a small pool so leds get revisited, sometimes anywhere
	function automatic logic [7:0] pick_led(int lo, int hi);
		if ($urandom_range(0, 4) != 0) begin
			return 8'($urandom_range(lo, hi));
		end
		return 8'($urandom);
	endfunction

	function automatic logic [31:0] pick_word();
		return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
	endfunction

	task automatic offer(logic [7:0] led, logic first, logic [31:0] word,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		item_t it;
		it.led_index = led;
		it.first_of_frame = first;
		it.random_word = word;
		it.cur_red = r;
		it.cur_green = g;
		it.cur_blue = b;
		item_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic offer_random(logic [7:0] led, logic first, logic [31:0] word);
		offer(led, first, word, pick_byte(), pick_byte(), pick_byte());
	endtask

	// one register write transfer; the predictor takes it at the same edge
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_MODE) begin
			mode_q = val[1:0];
		end else begin
			cycle_q = val;
		end
	endtask

	task automatic set_regs(logic [1:0] m, logic [CYCLE_W-1:0] span);
		write_reg(REG_MODE, DATA_W'(m));
		write_reg(REG_CYCLE, span);
		@(negedge clk);
	endtask

	// wait until every item has gone in and every colour has come back
	task automatic drain();
		while (item_backlog.size() != 0 || item_ch.valid || colour_expect.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	// leave the shared frame retarget flag set: one frame whose counter matches
	task automatic arm_frame_retarget();
		drain();
		set_regs(MODE_SHARED, frame_cnt);
		offer_random(pick_led(0, 15), 1'b1, pick_word());
		drain();
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// driver: a transfer feeds the predictor, then the next item or a gap
	always @(posedge clk) begin : driver
		if (item_ch.valid && item_ch.ready) begin
			colour_expect.push_back(predict_colour(item_ch.payload));
			send_gap = pick_gap(no_idle);
		end
		// an offer that has not been taken stands as it is
		if (!item_ch.valid || item_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (item_backlog.size() != 0) begin
				item_ch.payload <= item_backlog.pop_front();
				item_ch.valid <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result transfer with the oldest prediction
	always @(posedge clk) begin : monitor
		result_t want;
		result_t got;
		if (result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			if (colour_expect.size() == 0) begin
				$display("%0t: result for led %0d with nothing expected", $time, got.out_index);
				mismatches++;
			end else begin
				want = colour_expect.pop_front();
				check_field("out_index", want.out_index, got.out_index);
				check_field("red", want.red, got.red);
				check_field("green", want.green, got.green);
				check_field("blue", want.blue, got.blue);
				check_field("retargeted", 8'(want.retargeted), 8'(got.retargeted));
			end
		end
		// one long hold-off so the engine backs up into its input
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left = pick_gap(no_idle);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: run timed out", $time);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [CYCLE_W-1:0] span;
		logic               first;
		int                 n;
		int                 f;
		int                 i;
		int                 j;
		int                 kind;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		for (i = 0; i < 3 * LEDS; i++) begin
			fade_acc[i] = '0;
			fade_inc[i] = '0;
		end
		for (i = 0; i < LEDS; i++) begin
			visit_count[i] = '0;
			visit_period[i] = '0;
		end
		frame_cnt = CYCLE_RESET;
		frame_hit = 1'b0;
		mode_q = MODE_SHARED;
		cycle_q = CYCLE_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: the counter starts at its match, so frame one retargets
		// the extreme leds up from black and down from full
		offer(8'd0, 1'b1, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
		offer(8'd255, 1'b0, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
		offer(8'd1, 1'b0, 32'h8080_8080, 8'h7F, 8'h80, 8'h01);

		// retarget still pending with a zero frame count: the colour holds
		drain();
		set_regs(MODE_SHARED, 16'd0);
		offer(8'd2, 1'b0, 32'hFF00_FF00, 8'h12, 8'h34, 8'h56);
		offer(8'd2, 1'b1, 32'h00FF_00FF, 8'h9A, 8'hBC, 8'hDE);

		// short shared fade, then a plain frame that runs past both rails
		drain();
		set_regs(MODE_SHARED, frame_cnt);
		offer(8'd0, 1'b1, 32'h00FF_FFFF, 8'h00, 8'h00, 8'h00);
		offer(8'd1, 1'b0, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
		offer_random(8'd0, 1'b1, pick_word());
		offer_random(8'd0, 1'b0, pick_word());
		offer_random(8'd0, 1'b0, pick_word());
		offer_random(8'd1, 1'b0, pick_word());
		offer_random(8'd1, 1'b0, pick_word());
		offer_random(8'd1, 1'b0, pick_word());

		// per-led periods: below the minimum, at it, the longest; one led runs a full period
		drain();
		set_regs(MODE_PER_LED, 16'hFFFF);
		offer(8'd3, 1'b0, 32'h0012_3456, 8'h00, 8'hFF, 8'h80);
		offer(8'd4, 1'b1, 32'hFFAB_CDEF, 8'hFF, 8'h00, 8'h7F);
		offer(8'd5, 1'b0, 32'h0B00_FF00, 8'h55, 8'hAA, 8'h00);
		for (i = 0; i < 10; i++) begin
			offer_random(8'd3, 1'(i), pick_word());
		end

		// direct colour and the unused mode
		drain();
		set_regs(MODE_DIRECT, 16'd0);
		offer_random(8'd7, 1'b1, 32'hFFFF_FFFF);
		drain();
		set_regs(MODE_UNUSED, 16'd100);
		offer_random(8'd8, 1'b0, 32'h5A5A_A5A5);

		// largest step, then long enough unretargeted visits to wrap the accumulator
		arm_frame_retarget();
		set_regs(MODE_SHARED, 16'd1);
		offer(8'd30, 1'b0, 32'h00FF_FFFF, 8'h00, 8'h00, 8'h00);
		offer(8'd31, 1'b0, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF);
		for (j = 0; j < 132; j++) begin
			offer_random(8'd30, 1'(j == 0), pick_word());
			offer_random(8'd31, 1'b0, pick_word());
		end

		// back-pressure: receiver holds off while the sender keeps offering
		drain();
		no_idle = 1'b1;
		set_regs(MODE_DIRECT, cycle_q);
		hold_go = 1'b1;
		for (i = 0; i < 60; i++) begin
			offer_random(pick_led(0, 255), 1'($urandom), pick_word());
		end

		while (items_queued < ITEMS) begin
			drain();
			no_idle = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				// shared fades over short frames, with the odd misplaced frame start
				span = frame_cnt + CYCLE_W'($urandom_range(0, 3));
				set_regs(MODE_SHARED, span);
				n = $urandom_range(3, 10);
				for (f = 0; f < n; f++) begin
					j = $urandom_range(1, 6);
					for (i = 0; i < j; i++) begin
						first = (i == 0);
						if ($urandom_range(0, 15) == 0) begin
							first = ~first;
						end
						offer_random(pick_led(0, 15), first, pick_word());
					end
				end
			end else if (kind < 8) begin
				// per-led fades on a handful of leds, periods often short
				set_regs(MODE_PER_LED, CYCLE_W'($urandom));
				n = $urandom_range(40, 120);
				for (i = 0; i < n; i++) begin
					offer_random(pick_led(16, 19), 1'($urandom),
						{($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 16)) : pick_byte(),
						pick_byte(), pick_byte(), pick_byte()});
				end
			end else if (kind == 8) begin
				set_regs(($urandom_range(0, 1) != 0) ? MODE_DIRECT : MODE_UNUSED, CYCLE_W'($urandom));
				n = $urandom_range(10, 30);
				for (i = 0; i < n; i++) begin
					offer_random(pick_led(0, 255), 1'($urandom), pick_word());
				end
			end else begin
				// frame counts at the extremes with a retarget left pending
				arm_frame_retarget();
				case ($urandom_range(0, 2))
					0: begin
						span = 16'd0;
					end
					1: begin
						span = 16'd1;
					end
					default: begin
						span = 16'hFFFF;
					end
				endcase
				set_regs(MODE_SHARED, span);
				n = $urandom_range(5, 15);
				for (i = 0; i < n; i++) begin
					offer_random(pick_led(0, 15), 1'($urandom_range(0, 5) == 0), pick_word());
				end
			end
		end

		drain();
		repeat (4 * 3 * (10 + FRAC)) @(negedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
